>>> hdl/htfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_pkg: shared types and constants of the sensor frame decoder
// result codes, queue record layout, crc-8 step function, scale constants
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int unsigned FRAME_LAST_POS   = 6;       // position of the crc byte
  localparam int unsigned RAW_W            = 20;      // width of one raw value
  localparam int unsigned DATA_W           = 2 * RAW_W;
  localparam int unsigned FULL_SCALE_SHIFT = 20;
  localparam int unsigned HALF_LSB         = 524288;  // 2^19, rounding bias
  localparam int unsigned HUM_SCALE        = 100;
  localparam int unsigned TEMP_SCALE       = 200;
  localparam int unsigned TEMP_OFFSET      = 50;
  localparam int unsigned PROD_H_W         = 27;      // holds raw*100 + bias
  localparam int unsigned PROD_T_W         = 28;      // holds raw*200 + bias
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  localparam logic [7:0] CRC_POLY  = 8'h31;
  localparam logic [7:0] CRC_INIT  = 8'hFF;
  localparam int unsigned BUSY_BIT = 7;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_BUSY = 2'd1,
    STAT_CRC  = 2'd2
  } result_status_t;

  // one completed frame, classified, waiting for conversion
  typedef struct packed {
    result_status_t    kind;
    logic [RAW_W-1:0]  raw_h;
    logic [RAW_W-1:0]  raw_t;
  } frame_rec_t;

  // msb-first crc-8 over one byte, eight shift steps
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/htfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_if: valid/ready channels of the sensor frame decoder
// byte input channel, frame record channel and result channel
// ----------------------------------------------------------------------------
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_first;

  modport source (output valid, output frame_byte, output frame_first, input ready);
  modport sink   (input valid, input frame_byte, input frame_first, output ready);
endinterface

interface htfd_rec_if;
  import htfd_pkg::*;
  logic       valid;
  logic       ready;
  frame_rec_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface htfd_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        result_status;
  logic [6:0]        humidity_pct;
  logic signed [8:0] temperature_c;

  modport source (output valid, output result_status, output humidity_pct,
                  output temperature_c, input ready);
  modport sink   (input valid, input result_status, input humidity_pct,
                  input temperature_c, output ready);
endinterface

>>> hdl/humidity_temp_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder: sensor response frame check and conversion
// takes seven frame bytes, checks crc-8 and busy, converts humidity/temperature
// ----------------------------------------------------------------------------
// result path: the edge that accepts the crc byte writes the queue, then the record
//   passes the multiply stage and the round/offset output register
// throughput: one byte per cycle while the queue has room; one result per seven bytes
// the queue absorbs output stalls; input stalls only when the queue is full
// reset (rst_n low, synchronous): position 0, crc 0xff, busy clear, queue empty,
//   no result pending; collected data bytes are not reset
module humidity_temp_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  htfd_in_if.sink    in_ch,
  htfd_out_if.source out_ch
);
  import htfd_pkg::*;

  // classified frame records from front to queue, and queue to back
  htfd_rec_if front_rec ();
  htfd_rec_if back_rec ();

  // front: byte position, running crc, busy flag and data shift register
  htfd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .rec_ch (front_rec)
  );

  // queue decouples the byte intake from the conversion and output stall
  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_ch (front_rec),
    .rd_ch (back_rec)
  );

  // back: scale multiply, then round-half-up shift and temperature offset
  htfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .rec_ch (back_rec),
    .out_ch (out_ch)
  );

endmodule

>>> hdl/htfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_front: byte intake and frame classification
// tracks byte position, running crc, busy flag and data; emits a record per frame
// ----------------------------------------------------------------------------
module htfd_front (
  input  logic         clk,
  input  logic         rst_n,
  htfd_in_if.sink      in_ch,
  htfd_rec_if.source   rec_ch
);
  import htfd_pkg::*;

  logic [2:0]        pos_r,  pos_nxt;
  logic [7:0]        crc_r,  crc_nxt;
  logic              busy_r, busy_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  logic [2:0]     eff_pos;
  logic           is_last;
  logic           accept;
  result_status_t rec_kind;

  // restart mark or out-of-range position starts a new frame
  assign eff_pos = (in_ch.frame_first || (pos_r > 3'(FRAME_LAST_POS))) ? 3'd0 : pos_r;
  assign is_last = (eff_pos == 3'(FRAME_LAST_POS));

  assign in_ch.ready = rec_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign rec_ch.valid = in_ch.valid && is_last;
  assign rec_ch.data  = '{kind:  rec_kind,
                          raw_h: data_r[DATA_W-1:RAW_W],
                          raw_t: data_r[RAW_W-1:0]};

  always_comb begin
    priority if (busy_r) begin
      rec_kind = STAT_BUSY;
    end else if (crc_r != in_ch.frame_byte) begin
      rec_kind = STAT_CRC;
    end else begin
      rec_kind = STAT_OK;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    busy_nxt = busy_r;
    data_nxt = data_r;
    if (accept) begin
      priority if (eff_pos == 3'd0) begin
        crc_nxt  = crc8_feed(CRC_INIT, in_ch.frame_byte);
        busy_nxt = in_ch.frame_byte[BUSY_BIT];
        pos_nxt  = 3'd1;
      end else if (!is_last) begin
        crc_nxt  = crc8_feed(crc_r, in_ch.frame_byte);
        data_nxt = {data_r[DATA_W-9:0], in_ch.frame_byte};
        pos_nxt  = eff_pos + 3'd1;
      end else begin
        pos_nxt  = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 3'd0;
      crc_r  <= CRC_INIT;
      busy_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> hdl/htfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_queue: small record queue between front and back
// register array with read and write pointers and an occupancy count
// ----------------------------------------------------------------------------
module htfd_queue #(
  parameter int unsigned DEPTH = htfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  htfd_rec_if.sink    wr_ch,
  htfd_rec_if.source  rd_ch
);
  import htfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic             push, pop;

  assign wr_ch.ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_ch.valid = (cnt_r != '0);
  assign rd_ch.data  = mem[rd_ptr_r];

  assign push = wr_ch.valid && wr_ch.ready;
  assign pop  = rd_ch.valid && rd_ch.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_ch.data;
    end
  end

endmodule

>>> hdl/htfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_back: raw value conversion and result register
// stage one multiplies by the scale, stage two rounds, shifts and offsets
// ----------------------------------------------------------------------------
module htfd_back (
  input  logic        clk,
  input  logic        rst_n,
  htfd_rec_if.sink    rec_ch,
  htfd_out_if.source  out_ch
);
  import htfd_pkg::*;

  logic                s1_v_r;
  result_status_t      s1_kind_r;
  logic [PROD_H_W-1:0] s1_prod_h_r;
  logic [PROD_T_W-1:0] s1_prod_t_r;

  logic                out_v_r;
  logic [1:0]          status_r;
  logic [6:0]          hum_r;
  logic signed [8:0]   temp_r;

  logic                s1_en, out_en;
  logic [PROD_H_W-1:0] rnd_h;
  logic [PROD_T_W-1:0] rnd_t;
  logic [7:0]          temp_u;

  assign out_en      = !out_v_r || out_ch.ready;
  assign s1_en       = !s1_v_r || out_en;
  assign rec_ch.ready = s1_en;

  assign rnd_h  = s1_prod_h_r + PROD_H_W'(HALF_LSB);
  assign rnd_t  = s1_prod_t_r + PROD_T_W'(HALF_LSB);
  assign temp_u = rnd_t[PROD_T_W-1:FULL_SCALE_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= rec_ch.valid;
      end
      if (out_en) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && rec_ch.valid) begin
      s1_kind_r   <= rec_ch.data.kind;
      s1_prod_h_r <= PROD_H_W'(rec_ch.data.raw_h) * PROD_H_W'(HUM_SCALE);
      s1_prod_t_r <= PROD_T_W'(rec_ch.data.raw_t) * PROD_T_W'(TEMP_SCALE);
    end
    if (out_en && s1_v_r) begin
      status_r <= s1_kind_r;
      if (s1_kind_r == STAT_OK) begin
        hum_r  <= rnd_h[PROD_H_W-1:FULL_SCALE_SHIFT];
        temp_r <= $signed({1'b0, temp_u}) - $signed(9'(TEMP_OFFSET));
      end else begin
        hum_r  <= '0;
        temp_r <= '0;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.result_status = status_r;
  assign out_ch.humidity_pct  = hum_r;
  assign out_ch.temperature_c = temp_r;

endmodule

>>> hdl/htfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_checker: port-level checks of the sensor frame decoder
// result hold under stall, field ranges and reset behavior
// ----------------------------------------------------------------------------
module htfd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        result_status,
  input logic [6:0]        humidity_pct,
  input logic signed [8:0] temperature_c
);
  import htfd_pkg::*;

  // a stalled result stays and holds its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_status) &&
      $stable(humidity_pct) && $stable(temperature_c))
    else $error("result changed while stalled");

  // busy or crc mismatch carries zero readings
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_status != STAT_OK) |-> (humidity_pct == 7'd0) &&
      (temperature_c == 9'sd0))
    else $error("non-zero reading on error result");

  // converted readings stay in the sensor range
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_status == STAT_OK) |-> (humidity_pct <= 7'd100) &&
      (temperature_c >= -9'sd50) && (temperature_c <= 9'sd150))
    else $error("reading out of range");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .result_status (out_ch.result_status),
  .humidity_pct  (out_ch.humidity_pct),
  .temperature_c (out_ch.temperature_c)
);
